@@ hw/rtl/wflp_pkg.sv @@
package wflp_pkg;

  // Field and register widths
  localparam int DUTY_W     = 16;
  localparam int SUPPLY_W   = 16;
  localparam int DT_W       = 16;
  localparam int SPEED_W    = 32;
  localparam int COUNT_W    = 17;
  localparam int ACC_W      = 64;
  localparam int GAIN_W     = 24;
  localparam int LAG_W      = 16;
  localparam int CPM_W      = 24;
  localparam int MOD_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEADY_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_TIME      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_MM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODULUS = 2'd3;

  localparam logic [MOD_W-1:0] MOD_RESET = 17'd65536;
  localparam logic [MOD_W-1:0] MOD_MIN   = 17'd2;
  localparam logic [MOD_W-1:0] MOD_MAX   = 17'd65536;

  // Shared multiplier: 32 x 24 unsigned
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [2:0] MUL_DUTY_SUPPLY = 3'd0;
  localparam logic [2:0] MUL_TGT_GAIN    = 3'd1;
  localparam logic [2:0] MUL_DIFF_DT     = 3'd2;
  localparam logic [2:0] MUL_SPEED_DT    = 3'd3;
  localparam logic [2:0] MUL_ALO_CPM     = 3'd4;
  localparam logic [2:0] MUL_AHI_CPM     = 3'd5;

  // Shared divider: three quotient bits per cycle while stepping
  localparam int DIV_RADIX_BITS = 3;
  localparam int DIV_W          = 63;
  localparam int DIV_D_W        = 17;
  localparam int DIV_CNT_W      = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_CYC_STEP = 5'd16;
  localparam logic [DIV_CNT_W-1:0] DIV_CYC_CNT  = 5'd21;
  localparam logic [DIV_CNT_W-1:0] DIV_CYC_MOD  = 5'd16;

  // 256000 = 2^11 * 125
  localparam logic [6:0] CNT_DIVISOR = 7'd125;

  localparam logic [1:0] DIV_SRC_STEP = 2'd0;
  localparam logic [1:0] DIV_SRC_CNT  = 2'd1;
  localparam logic [1:0] DIV_SRC_MOD  = 2'd2;

  localparam logic [1:0] SPD_HOLD   = 2'd0;
  localparam logic [1:0] SPD_ZERO   = 2'd1;
  localparam logic [1:0] SPD_TARGET = 2'd2;
  localparam logic [1:0] SPD_STEP   = 2'd3;

  typedef struct packed {
    logic       in_load;
    logic       mul_en;
    logic       part_en;
    logic [2:0] mul_sel;
    logic       diff_en;
    logic       div_load;
    logic [1:0] div_src;
    logic       div_step;
    logic [1:0] spd_op;
    logic       acc_en;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic stall;
    logic snap;
  } dp_stat_t;

endpackage

@@ hw/rtl/wflp_div.sv @@
module wflp_div (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [wflp_pkg::DIV_W-1:0]   dividend,
  input  logic [wflp_pkg::DIV_D_W-1:0] divisor,
  output logic [wflp_pkg::DIV_W-1:0]   quot,
  output logic [wflp_pkg::DIV_D_W-1:0] rem
);
  import wflp_pkg::*;

  logic [DIV_W-1:0]   q_r, q_nxt;
  logic [DIV_D_W-1:0] rem_r, rem_nxt;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W:0]   trial;

  // Restoring division, DIV_RADIX_BITS bits per cycle while step is high; dividend enters left-aligned
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    trial   = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial = {rem_nxt, q_nxt[DIV_W-1]};
      q_nxt = {q_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt  = DIV_D_W'(trial - {1'b0, d_r});
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DIV_D_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = q_r;
  assign rem  = rem_r;

endmodule

@@ hw/rtl/wflp_dp.sv @@
module wflp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wflp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wflp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [wflp_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  wflp_pkg::dp_cmd_t                 cmd,
  output wflp_pkg::dp_stat_t                stat,
  output logic [wflp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import wflp_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0] gain_r;
  logic [LAG_W-1:0]  lag_r;
  logic [CPM_W-1:0]  cpm_r;
  logic [MOD_W-1:0]  mod_r;

  // Latched transaction
  logic [DUTY_W-1:0]   duty_r;
  logic [SUPPLY_W-1:0] supply_r;
  logic [DT_W-1:0]     dt_r;
  logic                stall_r;

  // Working registers
  logic [MUL_P_W-1:0] mul_r;
  logic [47:0]        part_r;
  logic [27:0]        target_r;
  logic [31:0]        diffmag_r;
  logic               dneg_r;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [ACC_W-1:0]   acc_r;
  logic [OUT_TDATA_W-1:0] out_r;

  logic [DUTY_W-1:0]  dmag;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] product;
  logic [26:0]        tmag;
  logic [27:0]        target_w;
  logic [32:0]        diff33;
  logic [31:0]        diffmag_w;
  logic [31:0]        smag;
  logic [71:0]        xsum;
  logic [46:0]        hmag;
  logic [MOD_W-1:0]   mod_c;
  logic [DIV_W-1:0]   div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic [DIV_W-1:0]   div_quot;
  logic [DIV_D_W-1:0] div_rem;
  logic [64:0]        inc65, s65, sum65;
  logic [ACC_W-1:0]   acc_sat;
  logic [MOD_W-1:0]   hm;
  logic               wrap_gt;
  logic [17:0]        raw_w;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      lag_r  <= '0;
      cpm_r  <= '0;
      mod_r  <= MOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEADY_GAIN:   gain_r <= cfg_wdata;
        REG_LAG_TIME:      lag_r  <= cfg_wdata[LAG_W-1:0];
        REG_COUNTS_PER_MM: cpm_r  <= cfg_wdata;
        REG_COUNT_MODULUS: mod_r  <= cfg_wdata[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      duty_r   <= in_tdata[15:0];
      supply_r <= in_tdata[31:16];
      dt_r     <= in_tdata[47:32];
      stall_r  <= in_tuser;
    end
  end

  assign stat.dt_zero = (dt_r == '0);
  assign stat.stall   = stall_r;
  assign stat.snap    = (lag_r == '0) || (dt_r >= lag_r);

  // Operand selection for the shared multiplier
  assign dmag = duty_r[DUTY_W-1] ? (DUTY_W'(0) - duty_r) : duty_r;
  assign smag = speed_r[SPEED_W-1] ? (32'd0 - speed_r) : speed_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_DUTY_SUPPLY: begin
        mul_a = {16'd0, dmag};
        mul_b = {8'd0, supply_r};
      end
      MUL_TGT_GAIN: begin
        mul_a = mul_r[31:0];
        mul_b = gain_r;
      end
      MUL_DIFF_DT: begin
        mul_a = diffmag_r;
        mul_b = {8'd0, dt_r};
      end
      MUL_SPEED_DT: begin
        mul_a = smag;
        mul_b = {8'd0, dt_r};
      end
      MUL_ALO_CPM: begin
        mul_a = {8'd0, mul_r[23:0]};
        mul_b = cpm_r;
      end
      MUL_AHI_CPM: begin
        mul_a = {8'd0, mul_r[47:24]};
        mul_b = cpm_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      mul_r <= product;
    end
    if (cmd.part_en) begin
      part_r <= product[47:0];
    end
  end

  // Target speed and distance to it
  assign tmag      = mul_r[55:29];
  assign target_w  = duty_r[DUTY_W-1] ? (28'd0 - {1'b0, tmag}) : {1'b0, tmag};
  assign diff33    = {{5{target_w[27]}}, target_w} - {speed_r[31], speed_r};
  assign diffmag_w = diff33[32] ? 32'(33'd0 - diff33) : diff33[31:0];

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      target_r  <= target_w;
      diffmag_r <= diffmag_w;
      dneg_r    <= diff33[32];
    end
  end

  // Divider operands
  assign xsum  = {mul_r[47:0], 24'd0} + {24'd0, part_r};
  assign hmag  = acc_r[63] ? ~acc_r[62:16] : acc_r[62:16];
  assign mod_c = (mod_r < MOD_MIN) ? MOD_MIN : ((mod_r > MOD_MAX) ? MOD_MAX : mod_r);

  always_comb begin
    case (cmd.div_src)
      DIV_SRC_STEP: begin
        div_dividend = {mul_r[47:0], 15'd0};
        div_divisor  = {1'b0, lag_r};
      end
      DIV_SRC_CNT: begin
        div_dividend = {2'd0, xsum[71:11]};
        div_divisor  = {10'd0, CNT_DIVISOR};
      end
      DIV_SRC_MOD: begin
        div_dividend = {1'b0, hmag, 15'd0};
        div_divisor  = mod_c;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  wflp_div u_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Speed update
  always_comb begin
    case (cmd.spd_op)
      SPD_ZERO:   speed_nxt = '0;
      SPD_TARGET: speed_nxt = {{4{target_r[27]}}, target_r};
      SPD_STEP:   speed_nxt = dneg_r ? (speed_r - div_quot[31:0])
                                     : (speed_r + div_quot[31:0]);
      default:    speed_nxt = speed_r;
    endcase
  end

  // Saturating count accumulation
  assign inc65   = {11'd0, div_quot[53:0]};
  assign s65     = speed_r[SPEED_W-1] ? (65'd0 - inc65) : inc65;
  assign sum65   = {acc_r[63], acc_r} + s65;
  assign acc_sat = (sum65[64] != sum65[63]) ?
                   (sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum65[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
      acc_r   <= '0;
    end else begin
      speed_r <= speed_nxt;
      if (cmd.acc_en) begin
        acc_r <= acc_sat;
      end
    end
  end

  // Wrap the count into the signed counter range, truncated toward zero
  assign hm      = acc_r[63] ? (mod_c - 17'd1 - div_rem) : div_rem;
  assign wrap_gt = {hm, acc_r[15:0]} > {1'b0, mod_c, 15'd0};
  assign raw_w   = wrap_gt ? ({1'b0, hm} - {1'b0, mod_c} + {17'd0, (acc_r[15:0] != 16'd0)})
                           : {1'b0, hm};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= {7'd0, raw_w[COUNT_W-1:0], speed_r};
    end
  end

  assign out_tdata = out_r;

endmodule

@@ hw/rtl/wflp_ctrl.sv @@
module wflp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  wflp_pkg::dp_stat_t  stat,
  output wflp_pkg::dp_cmd_t   cmd
);
  import wflp_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CHECK    = 5'd1;
  localparam logic [4:0] S_MUL_TG   = 5'd2;
  localparam logic [4:0] S_DIFF     = 5'd3;
  localparam logic [4:0] S_MUL_DT   = 5'd4;
  localparam logic [4:0] S_LD_STEP  = 5'd5;
  localparam logic [4:0] S_DIV_STEP = 5'd6;
  localparam logic [4:0] S_UPD      = 5'd7;
  localparam logic [4:0] S_MUL_A    = 5'd8;
  localparam logic [4:0] S_MUL_LO   = 5'd9;
  localparam logic [4:0] S_MUL_HI   = 5'd10;
  localparam logic [4:0] S_LD_CNT   = 5'd11;
  localparam logic [4:0] S_DIV_CNT  = 5'd12;
  localparam logic [4:0] S_ACC      = 5'd13;
  localparam logic [4:0] S_LD_MOD   = 5'd14;
  localparam logic [4:0] S_DIV_MOD  = 5'd15;
  localparam logic [4:0] S_WRAP     = 5'd16;

  logic [4:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Sequence one transaction through the shared multiplier and divider
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mul_sel = MUL_DUTY_SUPPLY;
    cmd.div_src = DIV_SRC_STEP;
    cmd.spd_op  = SPD_HOLD;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.in_load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DUTY_SUPPLY;
        if (stat.dt_zero) begin
          state_nxt = S_LD_MOD;
        end else if (stat.stall) begin
          cmd.spd_op = SPD_ZERO;
          state_nxt  = S_LD_MOD;
        end else begin
          state_nxt = S_MUL_TG;
        end
      end
      S_MUL_TG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TGT_GAIN;
        state_nxt   = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = S_MUL_DT;
      end
      S_MUL_DT: begin
        if (stat.snap) begin
          cmd.spd_op = SPD_TARGET;
          state_nxt  = S_MUL_A;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_DIFF_DT;
          state_nxt   = S_LD_STEP;
        end
      end
      S_LD_STEP: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DIV_SRC_STEP;
        cnt_nxt      = DIV_CYC_STEP;
        state_nxt    = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.spd_op = SPD_STEP;
        state_nxt  = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SPEED_DT;
        state_nxt   = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.part_en = 1'b1;
        cmd.mul_sel = MUL_ALO_CPM;
        state_nxt   = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AHI_CPM;
        state_nxt   = S_LD_CNT;
      end
      S_LD_CNT: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DIV_SRC_CNT;
        cnt_nxt      = DIV_CYC_CNT;
        state_nxt    = S_DIV_CNT;
      end
      S_DIV_CNT: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_LD_MOD;
      end
      S_LD_MOD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DIV_SRC_MOD;
        cnt_nxt      = DIV_CYC_MOD;
        state_nxt    = S_DIV_MOD;
      end
      S_DIV_MOD: begin
        cmd.div_step = 1'b1;
        cmd.div_src  = DIV_SRC_MOD;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ hw/rtl/wheel_first_order_lag_plant.sv @@
// Wheel plant: first-order lag speed model with an encoder count.
// Input stream: one transaction per tick. in_tdata carries duty, supply and
// elapsed_ms; in_tuser carries the stall flag. Output stream: one
// transaction per tick with the new speed and the wrapped raw count.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
// only between transactions (no tick in flight).
// Paths: a tick runs the full sequence when the lag is active, skips the lag
// step when the speed snaps to the target, and goes straight to the modulus
// step when the time step is zero or the stall flag is set. The shared
// radix-8 divider serves the lag step, the count increment and the counter
// modulus in turn. in_tready is high only while the block is idle;
// the next tick is taken in the cycle after the result is registered.
// A registered result waits for out_tready without blocking intake; the
// following result stalls in its final step until the output register frees.
// Reset (rst_n low, synchronous) clears speed, count and the output valid,
// and sets the registers to gain 0, lag 0, counts per mm 0, modulus 65536.
module wheel_first_order_lag_plant (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wflp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wflp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] duty, [31:16] supply, [47:32] elapsed_ms
  input  logic [wflp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] stall_hold
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] speed_out, [48:32] raw_count_out, [55:49] zero
  output logic [wflp_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import wflp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wflp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wflp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

  // One tick in flight: intake closes right after a transaction
  a_single_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a tick is in flight");

  // Wrapped count stays inside the signed counter range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[48:32]) >= -17'sd32768 &&
                    $signed(out_tdata[48:32]) <= 17'sd32768))
    else $error("raw count outside the counter range");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result pending after reset");

endmodule
